/* rtl/core/gibs_pkg.sv */
`default_nettype none

package gibs_pkg;

    // one pixel in Q12.4
    localparam logic [4:0] ONE_PIXEL = 5'd16;

    localparam logic [1:0] STATUS_SUPPRESSED = 2'd0;
    localparam logic [1:0] STATUS_KEPT       = 2'd1;
    localparam logic [1:0] STATUS_FULL       = 2'd2;

    // register byte addresses (bit 2 selects the register)
    localparam logic REG_IOU_THRESHOLD = 1'b0;
    localparam logic REG_CLASS_AWARE   = 1'b1;

    localparam logic [15:0] IOU_THRESHOLD_RESET = 16'd29491;
    localparam logic        CLASS_AWARE_RESET   = 1'b1;

    // one box with its inclusive-pixel area
    typedef struct packed {
        logic [30:0]        area;
        logic [7:0]         class_id;
        logic [14:0]        height;
        logic [14:0]        width;
        logic signed [15:0] top;
        logic signed [15:0] left;
    } box_t;

    typedef struct packed {
        logic busy;
        logic hit;
    } iou_status_t;

endpackage

`default_nettype wire

/* rtl/core/gibs_ram.sv */
`default_nettype none

module gibs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire                                            aclk,
    input  wire                                            we,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   waddr,
    input  wire  [WIDTH-1:0]                               wdata,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   raddr,
    output logic [WIDTH-1:0]                               rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* rtl/core/gibs_iou_unit.sv */
`default_nettype none

// Pipelined IoU test: one kept box per cycle, four register stages.
module gibs_iou_unit (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  in_valid,
    input  gibs_pkg::box_t       kept_box,
    input  gibs_pkg::box_t       new_box,
    input  wire                  class_aware,
    input  wire  [15:0]          iou_threshold,
    output gibs_pkg::iou_status_t status
);

    import gibs_pkg::*;

    logic signed [17:0] kept_right, new_right, kept_bottom, new_bottom;
    logic signed [17:0] min_right, min_bottom;
    logic signed [15:0] max_left, max_top;
    logic signed [18:0] iw_raw, ih_raw;
    logic [15:0]        iw, ih;
    logic               class_match;

    logic        s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic [15:0] s1_iw_reg, s1_ih_reg;
    logic [30:0] s1_area_reg, s2_area_reg;
    logic [30:0] s2_inter_reg, s3_inter_reg, s4_inter_reg;
    logic [31:0] s3_union_reg;
    logic [47:0] s4_rhs_reg;
    logic [31:0] product;
    logic [31:0] union_sum;
    logic [47:0] lhs;

    always_comb begin
        kept_right  = {{2{kept_box.left[15]}}, kept_box.left} + {3'b000, kept_box.width};
        new_right   = {{2{new_box.left[15]}}, new_box.left} + {3'b000, new_box.width};
        kept_bottom = {{2{kept_box.top[15]}}, kept_box.top} + {3'b000, kept_box.height};
        new_bottom  = {{2{new_box.top[15]}}, new_box.top} + {3'b000, new_box.height};
        min_right   = (kept_right < new_right) ? kept_right : new_right;
        min_bottom  = (kept_bottom < new_bottom) ? kept_bottom : new_bottom;
        max_left    = (kept_box.left > new_box.left) ? kept_box.left : new_box.left;
        max_top     = (kept_box.top > new_box.top) ? kept_box.top : new_box.top;
        iw_raw = {min_right[17], min_right} - {{3{max_left[15]}}, max_left}
                 + {14'd0, ONE_PIXEL};
        ih_raw = {min_bottom[17], min_bottom} - {{3{max_top[15]}}, max_top}
                 + {14'd0, ONE_PIXEL};
        // clamp disjoint extents to zero
        iw = iw_raw[18] ? 16'd0 : iw_raw[15:0];
        ih = ih_raw[18] ? 16'd0 : ih_raw[15:0];
        class_match = !class_aware || (kept_box.class_id == new_box.class_id);
    end

    assign product   = s1_iw_reg * s1_ih_reg;
    assign union_sum = {1'b0, s2_area_reg} + {1'b0, new_box.area} - {1'b0, s2_inter_reg};
    assign lhs       = {1'b0, s4_inter_reg, 16'd0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= in_valid && class_match;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        s1_iw_reg    <= iw;
        s1_ih_reg    <= ih;
        s1_area_reg  <= kept_box.area;
        s2_inter_reg <= product[30:0];
        s2_area_reg  <= s1_area_reg;
        s3_union_reg <= union_sum;
        s3_inter_reg <= s2_inter_reg;
        s4_rhs_reg   <= s3_union_reg * iou_threshold;
        s4_inter_reg <= s3_inter_reg;
    end

    // union always covers the larger area, so it stays positive
    assign status.hit  = s4_valid_reg && (lhs > s4_rhs_reg);
    assign status.busy = s1_valid_reg || s2_valid_reg || s3_valid_reg || s4_valid_reg;

endmodule

`default_nettype wire

/* rtl/core/greedy_iou_box_suppression_unit.sv */
`default_nettype none

// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  s_tdata box, s_tlast last_box
// m_        out  m_tvalid/m_tready  m_tdata index/total, m_tuser status
// apb       in   psel/penable       iou_threshold @0x0, class_aware @0x4
//
// From accept to accept, a box passes through area computation, one kept-box memory
// read per cycle, the drain of the four-stage IoU pipeline (shorter when the last
// kept boxes are of another class), then output load and idle.
// s_tready is high only in idle; the result waits in the output register while the
// next box is taken in, and that box holds in its done state until m_tready.
// Reset is synchronous; the kept-box memory needs no clearing pass.
module greedy_iou_box_suppression_unit #(
    parameter int MAX_KEPT = 64
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    // [15:0] box_left, [31:16] box_top, [46:32] box_width,
    // [61:47] box_height, [69:62] class_id, [71:70] zero
    input  wire  [71:0] s_tdata,
    input  wire         s_tlast,
    output logic        m_tvalid,
    input  wire         m_tready,
    // [14:0] box_index, [21:15] kept_total, [23:22] zero
    output logic [23:0] m_tdata,
    // [1:0] status
    output logic [1:0]  m_tuser,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    import gibs_pkg::*;

    localparam int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int CW = $clog2(MAX_KEPT + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_AREA  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [15:0]   iou_threshold_reg;
    logic          class_aware_reg;
    box_t          new_box_reg, new_box_next;
    logic          last_reg;
    logic [CW-1:0] kept_count_reg, kept_count_next;
    logic [CW-1:0] scan_idx_reg, scan_idx_next;
    logic [14:0]   box_counter_reg, box_counter_next;
    logic          hit_reg, hit_next;
    logic          rd_valid_reg;
    logic          m_tvalid_reg, m_tvalid_next;
    logic [23:0]   m_tdata_reg, m_tdata_next;
    logic [1:0]    m_tuser_reg, m_tuser_next;

    logic          issue;
    logic          ram_we;
    logic          finish;
    logic [CW-1:0] count_after;
    logic [31:0]   area_product;
    box_t          kept_box;
    iou_status_t   iou_status;
    logic          cfg_write;

    gibs_ram #(
        .WIDTH ($bits(box_t)),
        .DEPTH (MAX_KEPT)
    ) u_kept_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (kept_count_reg[AW-1:0]),
        .wdata (new_box_reg),
        .raddr (scan_idx_reg[AW-1:0]),
        .rdata (kept_box)
    );

    gibs_iou_unit u_iou (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (rd_valid_reg),
        .kept_box      (kept_box),
        .new_box       (new_box_reg),
        .class_aware   (class_aware_reg),
        .iou_threshold (iou_threshold_reg),
        .status        (iou_status)
    );

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_CLASS_AWARE) ? {31'd0, class_aware_reg}
                                                     : {16'd0, iou_threshold_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iou_threshold_reg <= IOU_THRESHOLD_RESET;
            class_aware_reg   <= CLASS_AWARE_RESET;
        end else if (cfg_write) begin
            if (paddr[2] == REG_IOU_THRESHOLD) begin
                iou_threshold_reg <= pwdata[15:0];
            end else begin
                class_aware_reg <= pwdata[0];
            end
        end
    end

    assign area_product = ({1'b0, new_box_reg.width} + {11'd0, ONE_PIXEL})
                        * ({1'b0, new_box_reg.height} + {11'd0, ONE_PIXEL});

    assign s_tready = (state_reg == ST_IDLE);
    assign issue    = (state_reg == ST_SCAN) && (scan_idx_reg != kept_count_reg);
    assign finish   = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);
    assign ram_we   = finish && !hit_reg && (kept_count_reg < CW'(MAX_KEPT));
    assign count_after = ram_we ? (kept_count_reg + CW'(1)) : kept_count_reg;

    always_comb begin
        state_next       = state_reg;
        new_box_next     = new_box_reg;
        scan_idx_next    = scan_idx_reg;
        hit_next         = hit_reg || iou_status.hit;
        kept_count_next  = kept_count_reg;
        box_counter_next = box_counter_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_tdata_next     = m_tdata_reg;
        m_tuser_next     = m_tuser_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    new_box_next.left     = s_tdata[15:0];
                    new_box_next.top      = s_tdata[31:16];
                    new_box_next.width    = s_tdata[46:32];
                    new_box_next.height   = s_tdata[61:47];
                    new_box_next.class_id = s_tdata[69:62];
                    scan_idx_next         = '0;
                    hit_next              = 1'b0;
                    state_next            = ST_AREA;
                end
            end
            ST_AREA: begin
                new_box_next.area = area_product[30:0];
                state_next        = ST_SCAN;
            end
            ST_SCAN: begin
                if (issue) begin
                    scan_idx_next = scan_idx_reg + CW'(1);
                end else begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!rd_valid_reg && !iou_status.busy) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (finish) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = hit_reg ? STATUS_SUPPRESSED
                                  : (ram_we ? STATUS_KEPT : STATUS_FULL);
                    m_tdata_next  = {2'b00, 7'(count_after), box_counter_reg};
                    kept_count_next = count_after;
                    if (box_counter_reg != 15'h7FFF) begin
                        box_counter_next = box_counter_reg + 15'd1;
                    end
                    // close the frame
                    if (last_reg) begin
                        kept_count_next  = '0;
                        box_counter_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            kept_count_reg  <= '0;
            box_counter_reg <= '0;
            rd_valid_reg    <= 1'b0;
            m_tvalid_reg    <= 1'b0;
            hit_reg         <= 1'b0;
        end else begin
            state_reg       <= state_next;
            kept_count_reg  <= kept_count_next;
            box_counter_reg <= box_counter_next;
            rd_valid_reg    <= issue;
            m_tvalid_reg    <= m_tvalid_next;
            hit_reg         <= hit_next;
        end
    end

    always_ff @(posedge aclk) begin
        new_box_reg  <= new_box_next;
        scan_idx_reg <= scan_idx_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
        if (s_tvalid && s_tready) begin
            last_reg <= s_tlast;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        kept_count_reg <= CW'(MAX_KEPT))
        else $error("kept count above store depth");

    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        issue |-> (scan_idx_reg < kept_count_reg))
        else $error("scan read beyond kept boxes");

    a_store_reports_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |=> (m_tvalid && m_tuser == STATUS_KEPT))
        else $error("stored box not reported as kept");

    a_idle_pipe_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (!rd_valid_reg && !iou_status.busy))
        else $error("compare pipeline active between boxes");

    a_suppress_needs_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (finish && !hit_reg) |=> (m_tuser != STATUS_SUPPRESSED))
        else $error("box suppressed without an overlap");

endmodule

`default_nettype wire
